@@ rtl/flow_switch_toggle_monitor_assert.svh @@
// Assertion macros for the flow switch toggle monitor.
`ifndef FLOW_SWITCH_TOGGLE_MONITOR_ASSERT_SVH
`define FLOW_SWITCH_TOGGLE_MONITOR_ASSERT_SVH

`ifndef SYNTH
`define FSTM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fstm assertion failed");
`define FSTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fstm assertion failed");
`else
`define FSTM_ASSERT_IMPLY(label, ante, cons)
`define FSTM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/fstm_pkg.sv @@
// Types and codes shared by the flow switch toggle monitor.
package fstm_pkg;

  localparam logic [2:0] EV_START   = 3'd0;
  localparam logic [2:0] EV_STOP    = 3'd1;
  localparam logic [2:0] EV_SEC     = 3'd2;
  localparam logic [2:0] EV_100MS   = 3'd3;
  localparam logic [2:0] EV_10MS    = 3'd4;
  localparam logic [2:0] EV_INSTANT = 3'd5;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_READY   = 2'd1;
  localparam logic [1:0] MODE_ACTIVE  = 2'd2;
  localparam logic [1:0] MODE_STOPPED = 2'd3;

  localparam logic [1:0] LEVEL_NONE = 2'd0;
  localparam logic [1:0] LEVEL_LOW  = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;

  localparam logic [2:0] REG_NO_FLOW   = 3'd0;
  localparam logic [2:0] REG_LOW_FLOW  = 3'd1;
  localparam logic [2:0] REG_HIGH_FLOW = 3'd2;
  localparam logic [2:0] REG_WINDOW    = 3'd3;
  localparam logic [2:0] REG_PERSIST   = 3'd4;

  localparam logic [15:0] NO_FLOW_RST   = 16'd50;
  localparam logic [15:0] LOW_FLOW_RST  = 16'd600;
  localparam logic [15:0] HIGH_FLOW_RST = 16'd3400;
  localparam logic [7:0]  WINDOW_RST    = 8'd3;
  localparam logic [3:0]  PERSIST_RST   = 4'd3;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [2:0] kind;
    logic       switch_level;
  } in_item_t;

  typedef struct packed {
    logic        report_valid;
    logic [15:0] report_count;
    logic        no_flow_alarm;
    logic        low_flow_alarm;
    logic        high_flow_alarm;
    logic        clear_alarms;
    logic [1:0]  mode;
  } out_item_t;

endpackage

@@ rtl/flow_switch_toggle_monitor.sv @@
// Flow switch toggle monitor: event decode, toggle counting, band alarms.
// One item per cycle, sustained while out_ready stays high. An item is taken
// into an input register; once the output register is free or being drained,
// the mode, counters and alarms are updated from it in one step, with its
// result loaded into the output register. in_ready drops only while both the
// input and the output register hold items and out_ready is low. Registers
// sit on the APB port at 0x00 no-flow limit, 0x04 low-flow limit, 0x08
// high-flow limit, 0x0C window ticks, 0x10 persistence limit; write them only
// when idle.
`include "flow_switch_toggle_monitor_assert.svh"

module flow_switch_toggle_monitor (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fstm_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fstm_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [15:0] no_flow_limit_r;
  logic [15:0] low_flow_limit_r;
  logic [15:0] high_flow_limit_r;
  logic [7:0]  window_ticks_r;
  logic [3:0]  persist_limit_r;

  logic                in_vld_r;
  fstm_pkg::in_item_t  in_r;
  logic                out_vld_r;
  fstm_pkg::out_item_t out_r;
  fstm_pkg::out_item_t out_nxt;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  last_level_r, last_level_nxt;
  logic [15:0] toggle_r, toggle_nxt;
  logic [7:0]  second_r, second_nxt;
  logic [3:0]  no_run_r, no_run_nxt;
  logic [3:0]  low_run_r, low_run_nxt;
  logic [3:0]  high_run_r, high_run_nxt;
  logic [2:0]  alarm_r, alarm_nxt;

  logic        proc_fire;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [1:0]  level_now;
  logic        do_sample;
  logic        do_sec;
  logic [7:0]  sec_inc;
  logic        close_win;
  logic        clear_pulse;
  logic [4:0]  no_run_inc;
  logic [4:0]  low_run_inc;
  logic [4:0]  high_run_inc;

  assign proc_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || proc_fire;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // config port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (cfg_idx)
      fstm_pkg::REG_NO_FLOW:   prdata = {16'd0, no_flow_limit_r};
      fstm_pkg::REG_LOW_FLOW:  prdata = {16'd0, low_flow_limit_r};
      fstm_pkg::REG_HIGH_FLOW: prdata = {16'd0, high_flow_limit_r};
      fstm_pkg::REG_WINDOW:    prdata = {24'd0, window_ticks_r};
      fstm_pkg::REG_PERSIST:   prdata = {28'd0, persist_limit_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      no_flow_limit_r   <= fstm_pkg::NO_FLOW_RST;
      low_flow_limit_r  <= fstm_pkg::LOW_FLOW_RST;
      high_flow_limit_r <= fstm_pkg::HIGH_FLOW_RST;
      window_ticks_r    <= fstm_pkg::WINDOW_RST;
      persist_limit_r   <= fstm_pkg::PERSIST_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fstm_pkg::REG_NO_FLOW:   no_flow_limit_r   <= pwdata[15:0];
        fstm_pkg::REG_LOW_FLOW:  low_flow_limit_r  <= pwdata[15:0];
        fstm_pkg::REG_HIGH_FLOW: high_flow_limit_r <= pwdata[15:0];
        fstm_pkg::REG_WINDOW:    window_ticks_r    <= pwdata[7:0];
        fstm_pkg::REG_PERSIST:   persist_limit_r   <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // event decode
  assign level_now = in_r.switch_level ? fstm_pkg::LEVEL_HIGH : fstm_pkg::LEVEL_LOW;
  assign do_sample = ((mode_r == fstm_pkg::MODE_ACTIVE) &&
                      ((in_r.kind == fstm_pkg::EV_10MS) || (in_r.kind == fstm_pkg::EV_INSTANT)))
                  || ((mode_r == fstm_pkg::MODE_READY) && (in_r.kind == fstm_pkg::EV_INSTANT));
  assign do_sec      = (mode_r == fstm_pkg::MODE_ACTIVE) && (in_r.kind == fstm_pkg::EV_SEC);
  assign sec_inc     = second_r + 8'd1;
  assign close_win   = do_sec && (sec_inc > window_ticks_r);
  assign clear_pulse = (mode_r == fstm_pkg::MODE_ACTIVE) && (in_r.kind == fstm_pkg::EV_STOP);
  assign no_run_inc   = {1'b0, no_run_r} + 5'd1;
  assign low_run_inc  = {1'b0, low_run_r} + 5'd1;
  assign high_run_inc = {1'b0, high_run_r} + 5'd1;

  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      fstm_pkg::MODE_IDLE: begin
        if (in_r.kind == fstm_pkg::EV_START) mode_nxt = fstm_pkg::MODE_READY;
      end
      fstm_pkg::MODE_READY: begin
        if (in_r.kind == fstm_pkg::EV_SEC) mode_nxt = fstm_pkg::MODE_ACTIVE;
      end
      fstm_pkg::MODE_ACTIVE: begin
        if (in_r.kind == fstm_pkg::EV_START) mode_nxt = fstm_pkg::MODE_READY;
        else if (in_r.kind == fstm_pkg::EV_STOP) mode_nxt = fstm_pkg::MODE_IDLE;
      end
      default: begin
        if (in_r.kind == fstm_pkg::EV_START) mode_nxt = fstm_pkg::MODE_ACTIVE;
      end
    endcase
  end

  always_comb begin
    last_level_nxt = last_level_r;
    toggle_nxt     = toggle_r;
    second_nxt     = second_r;
    no_run_nxt     = no_run_r;
    low_run_nxt    = low_run_r;
    high_run_nxt   = high_run_r;
    alarm_nxt      = alarm_r;
    if (do_sample && (level_now != last_level_r)) begin
      last_level_nxt = level_now;
      if (toggle_r != fstm_pkg::COUNT_MAX) toggle_nxt = toggle_r + 16'd1;
    end
    if (do_sec) begin
      second_nxt = sec_inc;
      if (close_win) begin
        second_nxt = 8'd0;
        toggle_nxt = 16'd0;
        if (toggle_r < no_flow_limit_r) begin
          if (no_run_inc > {1'b0, persist_limit_r}) begin
            no_run_nxt   = 4'd0;
            alarm_nxt[0] = 1'b1;
          end else begin
            no_run_nxt = no_run_inc[3:0];
          end
        end else if (toggle_r < low_flow_limit_r) begin
          if (low_run_inc > {1'b0, persist_limit_r}) begin
            low_run_nxt  = 4'd0;
            alarm_nxt[1] = 1'b1;
          end else begin
            low_run_nxt = low_run_inc[3:0];
          end
        end else if (toggle_r > high_flow_limit_r) begin
          if (high_run_inc > {1'b0, persist_limit_r}) begin
            high_run_nxt = 4'd0;
            alarm_nxt[2] = 1'b1;
          end else begin
            high_run_nxt = high_run_inc[3:0];
          end
        end else begin
          no_run_nxt   = 4'd0;
          low_run_nxt  = 4'd0;
          high_run_nxt = 4'd0;
        end
      end
    end
  end

  always_comb begin
    out_nxt.report_valid    = close_win;
    out_nxt.report_count    = close_win ? toggle_r : 16'd0;
    out_nxt.no_flow_alarm   = alarm_nxt[0];
    out_nxt.low_flow_alarm  = alarm_nxt[1];
    out_nxt.high_flow_alarm = alarm_nxt[2];
    out_nxt.clear_alarms    = clear_pulse;
    out_nxt.mode            = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
      mode_r       <= fstm_pkg::MODE_IDLE;
      last_level_r <= fstm_pkg::LEVEL_NONE;
      toggle_r     <= 16'd0;
      second_r     <= 8'd0;
      no_run_r     <= 4'd0;
      low_run_r    <= 4'd0;
      high_run_r   <= 4'd0;
      alarm_r      <= 3'd0;
    end else begin
      if (in_ready) in_vld_r <= in_valid;
      if (proc_fire) begin
        out_vld_r    <= 1'b1;
        mode_r       <= mode_nxt;
        last_level_r <= last_level_nxt;
        toggle_r     <= toggle_nxt;
        second_r     <= second_nxt;
        no_run_r     <= no_run_nxt;
        low_run_r    <= low_run_nxt;
        high_run_r   <= high_run_nxt;
        alarm_r      <= alarm_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_r <= in_data;
    if (proc_fire) out_r <= out_nxt;
  end

  `FSTM_ASSERT_NEXT(a_alarm_sticky, 1'b1, (alarm_r & $past(alarm_r)) == $past(alarm_r))
  `FSTM_ASSERT_IMPLY(a_clear_to_idle, out_vld_r && out_r.clear_alarms,
                     out_r.mode == fstm_pkg::MODE_IDLE)
  `FSTM_ASSERT_IMPLY(a_report_active, out_vld_r && out_r.report_valid,
                     out_r.mode == fstm_pkg::MODE_ACTIVE && toggle_r == 16'd0)
  `FSTM_ASSERT_IMPLY(a_count_zero, out_vld_r && !out_r.report_valid,
                     out_r.report_count == 16'd0)
  `FSTM_ASSERT_IMPLY(a_alarm_matches, out_vld_r,
                     {out_r.high_flow_alarm, out_r.low_flow_alarm, out_r.no_flow_alarm}
                     == alarm_r)

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the flow switch toggle monitor: directed table, bursts, random phases.
module testbench;

  localparam logic [2:0] EV_SPARE6  = 3'd6;
  localparam logic [2:0] EV_SPARE7  = 3'd7;
  localparam logic [2:0] REG_SPARE5 = 3'd5;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  localparam int ALARM_NO   = 0;
  localparam int ALARM_LOW  = 1;
  localparam int ALARM_HIGH = 2;

  localparam int LIMIT       = 100000;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic                typed;
    fstm_pkg::in_item_t  item;
    fstm_pkg::out_item_t exp;
  } dir_row_t;

  localparam fstm_pkg::out_item_t OUT_ANY    = '0;
  localparam fstm_pkg::out_item_t OUT_IDLE   =
    '{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, fstm_pkg::MODE_IDLE};
  localparam fstm_pkg::out_item_t OUT_READY  =
    '{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, fstm_pkg::MODE_READY};
  localparam fstm_pkg::out_item_t OUT_ACTIVE =
    '{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0, fstm_pkg::MODE_ACTIVE};
  localparam fstm_pkg::out_item_t OUT_CLEAR  =
    '{1'b0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1, fstm_pkg::MODE_IDLE};

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b1, '{fstm_pkg::EV_STOP,    1'b0}, OUT_IDLE},
    '{1'b1, '{EV_SPARE6,            1'b1}, OUT_IDLE},
    '{1'b1, '{EV_SPARE7,            1'b0}, OUT_IDLE},
    '{1'b1, '{fstm_pkg::EV_SEC,     1'b1}, OUT_IDLE},
    '{1'b1, '{fstm_pkg::EV_INSTANT, 1'b1}, OUT_IDLE},
    '{1'b1, '{fstm_pkg::EV_START,   1'b0}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_START,   1'b1}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_STOP,    1'b0}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_10MS,    1'b1}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_100MS,   1'b0}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_INSTANT, 1'b1}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_INSTANT, 1'b1}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_SEC,     1'b0}, OUT_ACTIVE},
    '{1'b1, '{fstm_pkg::EV_100MS,   1'b1}, OUT_ACTIVE},
    '{1'b1, '{EV_SPARE6,            1'b0}, OUT_ACTIVE},
    '{1'b0, '{fstm_pkg::EV_10MS,    1'b0}, OUT_ANY},
    '{1'b0, '{fstm_pkg::EV_INSTANT, 1'b1}, OUT_ANY},
    '{1'b0, '{fstm_pkg::EV_SEC,     1'b0}, OUT_ANY},
    '{1'b0, '{fstm_pkg::EV_SEC,     1'b1}, OUT_ANY},
    '{1'b0, '{fstm_pkg::EV_SEC,     1'b0}, OUT_ANY},
    '{1'b0, '{fstm_pkg::EV_SEC,     1'b1}, OUT_ANY},
    '{1'b1, '{fstm_pkg::EV_START,   1'b0}, OUT_READY},
    '{1'b1, '{fstm_pkg::EV_SEC,     1'b0}, OUT_ACTIVE},
    '{1'b1, '{fstm_pkg::EV_STOP,    1'b1}, OUT_CLEAR}
  };

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  fstm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  fstm_pkg::out_item_t out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  flow_switch_toggle_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // monitor state mirror
  logic [31:0] reg_shadow [0:7];
  logic [1:0]  st_mode;
  logic [1:0]  st_last;
  logic [15:0] st_toggles;
  logic [7:0]  st_secs;
  logic [3:0]  run_no;
  logic [3:0]  run_low;
  logic [3:0]  run_high;
  logic [2:0]  st_alarms;

  fstm_pkg::out_item_t report_q [$];
  int        errors = 0;
  int        cycles = 0;
  int        tx_idle = 0;
  int        rx_stall = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("flow_switch_toggle_monitor: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_stall);
  end

  task automatic check_field(string name, int unsigned e, int unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    fstm_pkg::out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      if (report_q.size() == 0) begin
        $error("out_data: item with no expectation pending");
        errors++;
      end else begin
        e = report_q.pop_front();
        check_field("report_valid", e.report_valid, out_data.report_valid);
        check_field("report_count", e.report_count, out_data.report_count);
        check_field("no_flow_alarm", e.no_flow_alarm, out_data.no_flow_alarm);
        check_field("low_flow_alarm", e.low_flow_alarm, out_data.low_flow_alarm);
        check_field("high_flow_alarm", e.high_flow_alarm, out_data.high_flow_alarm);
        check_field("clear_alarms", e.clear_alarms, out_data.clear_alarms);
        check_field("mode", e.mode, out_data.mode);
      end
    end
  end

  function automatic void take_sample(logic lvl);
    logic [1:0] now;
    now = lvl ? fstm_pkg::LEVEL_HIGH : fstm_pkg::LEVEL_LOW;
    if (now != st_last) begin
      st_last = now;
      if (st_toggles != fstm_pkg::COUNT_MAX) st_toggles = st_toggles + 16'd1;
    end
  endfunction

  function automatic logic [3:0] bump_run(logic [3:0] run, int alarm);
    logic [4:0] nxt;
    nxt = {1'b0, run} + 5'd1;
    if (nxt > {1'b0, reg_shadow[fstm_pkg::REG_PERSIST][3:0]}) begin
      st_alarms[alarm] = 1'b1;
      return 4'd0;
    end
    return nxt[3:0];
  endfunction

  function automatic fstm_pkg::out_item_t flow_predict(fstm_pkg::in_item_t it);
    fstm_pkg::out_item_t r;
    r = '0;
    case (st_mode)
      fstm_pkg::MODE_ACTIVE: begin
        if (it.kind == fstm_pkg::EV_START) begin
          st_mode = fstm_pkg::MODE_READY;
        end else if (it.kind == fstm_pkg::EV_STOP) begin
          r.clear_alarms = 1'b1;
          st_mode = fstm_pkg::MODE_IDLE;
        end else if (it.kind == fstm_pkg::EV_SEC) begin
          st_secs = st_secs + 8'd1;
          if (st_secs > reg_shadow[fstm_pkg::REG_WINDOW][7:0]) begin
            st_secs = 8'd0;
            r.report_valid = 1'b1;
            r.report_count = st_toggles;
            if (st_toggles < reg_shadow[fstm_pkg::REG_NO_FLOW][15:0]) begin
              run_no = bump_run(run_no, ALARM_NO);
            end else if (st_toggles < reg_shadow[fstm_pkg::REG_LOW_FLOW][15:0]) begin
              run_low = bump_run(run_low, ALARM_LOW);
            end else if (st_toggles > reg_shadow[fstm_pkg::REG_HIGH_FLOW][15:0]) begin
              run_high = bump_run(run_high, ALARM_HIGH);
            end else begin
              run_no = 4'd0;
              run_low = 4'd0;
              run_high = 4'd0;
            end
            st_toggles = 16'd0;
          end
        end else if (it.kind == fstm_pkg::EV_10MS || it.kind == fstm_pkg::EV_INSTANT) begin
          take_sample(it.switch_level);
        end
      end
      fstm_pkg::MODE_IDLE: begin
        if (it.kind == fstm_pkg::EV_START) st_mode = fstm_pkg::MODE_READY;
      end
      fstm_pkg::MODE_READY: begin
        if (it.kind == fstm_pkg::EV_SEC) st_mode = fstm_pkg::MODE_ACTIVE;
        else if (it.kind == fstm_pkg::EV_INSTANT) take_sample(it.switch_level);
      end
      default: begin
        if (it.kind == fstm_pkg::EV_START) st_mode = fstm_pkg::MODE_ACTIVE;
      end
    endcase
    r.no_flow_alarm = st_alarms[ALARM_NO];
    r.low_flow_alarm = st_alarms[ALARM_LOW];
    r.high_flow_alarm = st_alarms[ALARM_HIGH];
    r.mode = st_mode;
    return r;
  endfunction

  // mostly well-formed: start from idle, second tick from ready, samples and ticks while active
  function automatic fstm_pkg::in_item_t pick_event();
    fstm_pkg::in_item_t it;
    int unsigned        roll;
    roll = $urandom_range(0, 99);
    it.switch_level = 1'($urandom_range(0, 1));
    case (st_mode)
      fstm_pkg::MODE_IDLE:
        it.kind = (roll < 70) ? fstm_pkg::EV_START : 3'($urandom_range(1, 7));
      fstm_pkg::MODE_READY:
        it.kind = (roll < 45) ? fstm_pkg::EV_SEC :
                  (roll < 85) ? fstm_pkg::EV_INSTANT : 3'($urandom_range(0, 7));
      default:
        it.kind = (roll < 35) ? fstm_pkg::EV_INSTANT :
                  (roll < 60) ? fstm_pkg::EV_10MS :
                  (roll < 82) ? fstm_pkg::EV_SEC :
                  (roll < 85) ? fstm_pkg::EV_START :
                  (roll < 88) ? fstm_pkg::EV_STOP : 3'($urandom_range(0, 7));
    endcase
    return it;
  endfunction

  // entered and left at a falling edge
  task automatic send_item(fstm_pkg::in_item_t it, logic typed,
                           fstm_pkg::out_item_t typed_exp);
    fstm_pkg::out_item_t e;
    e = flow_predict(it);
    if (typed) e = typed_exp;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    report_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic send_repeat(logic [2:0] kind, int n, logic alternate);
    fstm_pkg::in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.kind = kind;
      it.switch_level = alternate ? i[0] : 1'($urandom_range(0, 1));
      send_item(it, 1'b0, OUT_ANY);
    end
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(logic wr, logic [2:0] idx, logic [31:0] wd);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wd;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr) begin
      case (idx)
        fstm_pkg::REG_NO_FLOW, fstm_pkg::REG_LOW_FLOW, fstm_pkg::REG_HIGH_FLOW:
          reg_shadow[idx] = {16'd0, wd[15:0]};
        fstm_pkg::REG_WINDOW:  reg_shadow[idx] = {24'd0, wd[7:0]};
        fstm_pkg::REG_PERSIST: reg_shadow[idx] = {28'd0, wd[3:0]};
        default: ;
      endcase
    end else if (prdata !== reg_shadow[idx]) begin
      $error("prdata[%0d]: expected %0d, actual %0d", idx, reg_shadow[idx], prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // upper bits carry junk; only the register width is kept
  task automatic load_limits(int nf, int lf, int hf, int win, int per);
    wait_results();
    apb_access(1'b1, fstm_pkg::REG_NO_FLOW, {16'($urandom), 16'(nf)});
    apb_access(1'b1, fstm_pkg::REG_LOW_FLOW, {16'($urandom), 16'(lf)});
    apb_access(1'b1, fstm_pkg::REG_HIGH_FLOW, {16'($urandom), 16'(hf)});
    apb_access(1'b1, fstm_pkg::REG_WINDOW, {24'($urandom), 8'(win)});
    apb_access(1'b1, fstm_pkg::REG_PERSIST, {28'($urandom), 4'(per)});
    apb_access(1'b1, $urandom_range(0, 1) ? REG_SPARE5 : REG_SPARE7, $urandom);
    for (int r = 0; r <= fstm_pkg::REG_PERSIST; r++) apb_access(1'b0, 3'(r), 32'd0);
  endtask

  initial begin
    int nf, lf, hf, win, per;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    for (int r = 0; r < 8; r++) reg_shadow[r] = 32'd0;
    reg_shadow[fstm_pkg::REG_NO_FLOW] = {16'd0, fstm_pkg::NO_FLOW_RST};
    reg_shadow[fstm_pkg::REG_LOW_FLOW] = {16'd0, fstm_pkg::LOW_FLOW_RST};
    reg_shadow[fstm_pkg::REG_HIGH_FLOW] = {16'd0, fstm_pkg::HIGH_FLOW_RST};
    reg_shadow[fstm_pkg::REG_WINDOW] = {24'd0, fstm_pkg::WINDOW_RST};
    reg_shadow[fstm_pkg::REG_PERSIST] = {28'd0, fstm_pkg::PERSIST_RST};
    st_mode = fstm_pkg::MODE_IDLE;
    st_last = fstm_pkg::LEVEL_NONE;
    st_toggles = 16'd0;
    st_secs = 8'd0;
    run_no = 4'd0;
    run_low = 4'd0;
    run_high = 4'd0;
    st_alarms = 3'd0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) send_item(DIR_TAB[i].item, DIR_TAB[i].typed, DIR_TAB[i].exp);

    // toggle counting in one long window
    send_repeat(fstm_pkg::EV_START, 1, 1'b0);
    send_repeat(fstm_pkg::EV_SEC, 1, 1'b0);
    send_repeat(fstm_pkg::EV_INSTANT, 40, 1'b1);
    send_repeat(fstm_pkg::EV_SEC, 4, 1'b0);

    // second counter wraps with a window that never closes
    load_limits(int'(fstm_pkg::NO_FLOW_RST), int'(fstm_pkg::LOW_FLOW_RST),
                int'(fstm_pkg::HIGH_FLOW_RST), 255, int'(fstm_pkg::PERSIST_RST));
    send_repeat(fstm_pkg::EV_SEC, 300, 1'b0);
    load_limits(int'(fstm_pkg::NO_FLOW_RST), int'(fstm_pkg::LOW_FLOW_RST),
                int'(fstm_pkg::HIGH_FLOW_RST), 10, int'(fstm_pkg::PERSIST_RST));
    send_repeat(fstm_pkg::EV_SEC, 1, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      nf = $urandom_range(0, 6);
      lf = nf + $urandom_range(0, 8);
      hf = lf + $urandom_range(0, 10);
      win = $urandom_range(0, 5);
      per = $urandom_range(0, 15);
      case (ph)
        0: begin nf = 3; lf = 8; hf = 12; win = 0; per = 15; end
        1: begin nf = 0; lf = 0; hf = 65535; win = 2; per = 7; end
        4: begin nf = 65535; lf = 65535; hf = 0; win = 1; per = 0; end
        5: begin nf = 0; lf = 65535; hf = 0; win = 1; per = 0; end
        6: begin nf = 0; lf = 0; hf = 0; win = 0; per = 15; end
        default: ;
      endcase
      load_limits(nf, lf, hf, win, per);
      case (ph % 4)
        0: begin tx_idle = 0; rx_stall = 0; end
        1: begin tx_idle = 51; rx_stall = 0; end
        2: begin tx_idle = 0; rx_stall = 51; end
        default: begin tx_idle = 19; rx_stall = 19; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) wait_results();
        send_item(pick_event(), 1'b0, OUT_ANY);
      end
      tx_idle = 0;
      rx_stall = 0;
    end

    wait_results();
    repeat (6) @(negedge clk);
    if (errors == 0) begin
      $display("flow_switch_toggle_monitor: match");
    end else begin
      $display("flow_switch_toggle_monitor: mismatch");
    end
    $finish;
  end

endmodule
